>>> sv/wsbf_pkg.sv
// Package for the wheel slip brake force block: payload structs, register codes,
// field widths and reset values. It has no dependencies and every other file uses it.
package wsbf_pkg;

  localparam int unsigned SLIP_FRAC_BITS_DEF = 14;

  localparam int unsigned WHEELS  = 4;
  localparam int unsigned SPEED_W = 16;
  localparam int unsigned SUM_W   = 18;
  localparam int unsigned REG_W   = 16;
  localparam int unsigned FORCE_W = 18;

  // Configuration register indexes.
  localparam logic [0:0] CFG_SLIP_THRESHOLD = 1'b0;
  localparam logic [0:0] CFG_FORCE_GAIN     = 1'b1;

  localparam logic [REG_W-1:0]   SLIP_THRESHOLD_RST = 16'd4915;
  localparam logic [REG_W-1:0]   FORCE_GAIN_RST     = 16'd300;
  localparam logic [FORCE_W-1:0] FORCE_MAX          = 18'd196605;

  typedef struct packed {
    logic [SPEED_W-1:0] speed_front_left;
    logic [SPEED_W-1:0] speed_front_right;
    logic [SPEED_W-1:0] speed_rear_left;
    logic [SPEED_W-1:0] speed_rear_right;
    logic               ok_front_left;
    logic               ok_front_right;
    logic               ok_rear_left;
    logic               ok_rear_right;
  } in_t;

  typedef struct packed {
    logic [FORCE_W-1:0] force_front_left;
    logic [FORCE_W-1:0] force_front_right;
    logic [FORCE_W-1:0] force_rear_left;
    logic [FORCE_W-1:0] force_rear_right;
  } out_t;

  // Masked wheel speeds (front left, front right, rear left, rear right) and their sum.
  typedef struct packed {
    logic [WHEELS-1:0][SPEED_W-1:0] speed;
    logic [SUM_W-1:0]               sum;
  } front_t;

endpackage

>>> sv/wsbf_front.sv
// Input stage of the wheel slip brake force block: masks invalid readings and
// sums the four speeds into one register stage. Depends on wsbf_pkg.
module wsbf_front (
  input  logic            clk_i,
  input  logic            en_i,
  input  wsbf_pkg::in_t    in_data_i,
  output wsbf_pkg::front_t front_o
);

  wsbf_pkg::front_t front_d, front_q;

  always_comb begin
    front_d.speed[0] = in_data_i.ok_front_left  ? in_data_i.speed_front_left  : '0;
    front_d.speed[1] = in_data_i.ok_front_right ? in_data_i.speed_front_right : '0;
    front_d.speed[2] = in_data_i.ok_rear_left   ? in_data_i.speed_rear_left   : '0;
    front_d.speed[3] = in_data_i.ok_rear_right  ? in_data_i.speed_rear_right  : '0;
    front_d.sum = wsbf_pkg::SUM_W'(front_d.speed[0]) + wsbf_pkg::SUM_W'(front_d.speed[1])
                + wsbf_pkg::SUM_W'(front_d.speed[2]) + wsbf_pkg::SUM_W'(front_d.speed[3]);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      front_q <= front_d;
    end
  end

  assign front_o = front_q;

endmodule

>>> sv/wsbf_lane.sv
// One wheel lane: deviation from the mean, a pipelined restoring divider with one
// quotient bit per stage, then threshold test and gain multiply. Depends on wsbf_pkg.
module wsbf_lane #(
  parameter int unsigned SLIP_FRAC_BITS = wsbf_pkg::SLIP_FRAC_BITS_DEF
) (
  input  logic                                  clk_i,
  input  logic [SLIP_FRAC_BITS+3:0]             en_i,
  input  logic [wsbf_pkg::SPEED_W-1:0]          speed_i,
  input  logic [wsbf_pkg::SUM_W-1:0]            sum_i,
  input  logic [wsbf_pkg::REG_W-1:0]            slip_threshold_i,
  input  logic [wsbf_pkg::REG_W-1:0]            force_gain_i,
  output logic [wsbf_pkg::FORCE_W-1:0]          force_o
);

  localparam int unsigned QW   = SLIP_FRAC_BITS + 2;
  localparam int unsigned LSTG = QW + 2;
  localparam int unsigned RW   = wsbf_pkg::SUM_W + 1;
  localparam int unsigned CW   = (QW > wsbf_pkg::REG_W) ? QW : wsbf_pkg::REG_W;
  localparam int unsigned PW   = wsbf_pkg::REG_W + QW;

  // Deviation stage: the mean is kept exact as sum/4, so compare 4*v with the sum.
  logic [wsbf_pkg::SUM_W-1:0] scaled;
  logic [wsbf_pkg::SUM_W-1:0] dev_d, dev_q;
  logic [wsbf_pkg::SUM_W-1:0] dsum_q;
  logic                       dzero_q;

  assign scaled = {speed_i, 2'b00};
  assign dev_d  = (scaled >= sum_i) ? (scaled - sum_i) : (sum_i - scaled);

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      dev_q   <= dev_d;
      dsum_q  <= sum_i;
      dzero_q <= (sum_i == '0);
    end
  end

  // Divider stages. The deviation is at most three times the sum, so the first stage
  // tests against twice the sum and every later stage against the sum itself.
  logic [RW-1:0]              r_q [QW];
  logic [QW-1:0]              q_q [QW];
  logic [wsbf_pkg::SUM_W-1:0] s_q [QW-1];
  logic                       z_q [QW];

  for (genvar k = 0; k < QW; k++) begin : g_div
    logic [RW-1:0] r_in;
    logic [RW-1:0] dvs;
    logic [QW-1:0] q_in;
    logic          z_in;
    logic          ge;
    logic [RW-1:0] rem;
    logic [RW-1:0] r_nxt;

    if (k == 0) begin : g_first
      assign r_in = {1'b0, dev_q};
      assign dvs  = {dsum_q, 1'b0};
      assign q_in = '0;
      assign z_in = dzero_q;
    end else begin : g_next
      assign r_in = r_q[k-1];
      assign dvs  = {1'b0, s_q[k-1]};
      assign q_in = q_q[k-1];
      assign z_in = z_q[k-1];
    end

    assign ge  = (r_in >= dvs);
    assign rem = ge ? (r_in - dvs) : r_in;
    if (k > 0 && k < QW - 1) begin : g_dbl
      assign r_nxt = {rem[RW-2:0], 1'b0};
    end else begin : g_keep
      assign r_nxt = rem;
    end

    always_ff @(posedge clk_i) begin
      if (en_i[k+1]) begin
        r_q[k] <= r_nxt;
        q_q[k] <= {q_in[QW-2:0], ge};
        z_q[k] <= z_in;
      end
    end

    if (k < QW - 1) begin : g_sum
      if (k == 0) begin : g_s0
        always_ff @(posedge clk_i) begin
          if (en_i[k+1]) begin
            s_q[k] <= dsum_q;
          end
        end
      end else begin : g_sn
        always_ff @(posedge clk_i) begin
          if (en_i[k+1]) begin
            s_q[k] <= s_q[k-1];
          end
        end
      end
    end
  end

  // Threshold test and force: braking only when the slip is strictly above the limit.
  logic [QW-1:0]                slip;
  logic                         brake;
  logic [PW-1:0]                prod;
  logic [wsbf_pkg::FORCE_W-1:0] force_d, force_q;

  assign slip    = q_q[QW-1];
  assign brake   = !z_q[QW-1] && (CW'(slip) > CW'(slip_threshold_i));
  assign prod    = PW'(force_gain_i) * PW'(slip);
  assign force_d = brake ? prod[SLIP_FRAC_BITS +: wsbf_pkg::FORCE_W] : '0;

  always_ff @(posedge clk_i) begin
    if (en_i[LSTG-1]) begin
      force_q <= force_d;
    end
  end

  assign force_o = force_q;

endmodule

>>> sv/wheel_slip_brake_force_top.sv
// Top level of the wheel slip brake force block: configuration registers, pipeline
// flow control, input stage and four wheel lanes merged into one result.
// Depends on wsbf_pkg, wsbf_front and wsbf_lane.
//
// Usage:
//   Input channel in_valid_i / in_ready_o / in_data_i carries four wheel speeds
//   with read-ok flags; output channel out_valid_o / out_ready_i / out_data_o
//   carries the four brake forces. A transaction happens when valid and ready are
//   both high at a rising edge of clk_i.
//   The pipeline is made of one input stage, one deviation stage, SLIP_FRAC_BITS + 2
//   divider stages with one quotient bit each, and one multiply stage that is also
//   the output register.
//   Throughput is one transaction per cycle while out_ready_i stays high; each lane holds one item per stage.
//   When the receiver stalls, each stage holds its item only if the stage after it
//   is full, so empty stages keep filling and in_ready_o falls only when every
//   stage is occupied.
//   Configuration is written through cfg_we_i / cfg_idx_i / cfg_data_i; the user
//   must do so only while the block is idle, which the block does not enforce.
//   Reset (rst_ni low) empties the pipeline, sets slip threshold 4915, force gain 300.
module wheel_slip_brake_force_top #(
  parameter int unsigned SLIP_FRAC_BITS = wsbf_pkg::SLIP_FRAC_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  wsbf_pkg::in_t                in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output wsbf_pkg::out_t               out_data_o,
  input  logic                        cfg_we_i,
  input  logic [0:0]                  cfg_idx_i,
  input  logic [wsbf_pkg::REG_W-1:0]  cfg_data_i
);

  localparam int unsigned NSTG = SLIP_FRAC_BITS + 5;

  // Configuration registers.
  logic [wsbf_pkg::REG_W-1:0] slip_threshold_q, force_gain_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slip_threshold_q <= wsbf_pkg::SLIP_THRESHOLD_RST;
      force_gain_q     <= wsbf_pkg::FORCE_GAIN_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        wsbf_pkg::CFG_SLIP_THRESHOLD: slip_threshold_q <= cfg_data_i;
        wsbf_pkg::CFG_FORCE_GAIN:     force_gain_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Flow control: a stage loads when it is empty or the stage after it moves on.
  logic [NSTG-1:0] valid_d, valid_q;
  logic [NSTG:0]   ready;

  always_comb begin
    ready[NSTG] = out_ready_i;
    for (int k = NSTG - 1; k >= 0; k--) begin
      ready[k] = !valid_q[k] || ready[k+1];
    end
    valid_d[0] = ready[0] ? in_valid_i : valid_q[0];
    for (int k = 1; k < NSTG; k++) begin
      valid_d[k] = ready[k] ? valid_q[k-1] : valid_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign in_ready_o  = ready[0];
  assign out_valid_o = valid_q[NSTG-1];

  // Input stage and lanes.
  wsbf_pkg::front_t front;

  wsbf_front u_front (
    .clk_i     (clk_i),
    .en_i      (ready[0]),
    .in_data_i (in_data_i),
    .front_o   (front)
  );

  logic [wsbf_pkg::WHEELS-1:0][wsbf_pkg::FORCE_W-1:0] lane_force;

  for (genvar w = 0; w < wsbf_pkg::WHEELS; w++) begin : g_lane
    wsbf_lane #(
      .SLIP_FRAC_BITS (SLIP_FRAC_BITS)
    ) u_lane (
      .clk_i            (clk_i),
      .en_i             (ready[NSTG-1:1]),
      .speed_i          (front.speed[w]),
      .sum_i            (front.sum),
      .slip_threshold_i (slip_threshold_q),
      .force_gain_i     (force_gain_q),
      .force_o          (lane_force[w])
    );
  end

  // Merge the lane results into one output transaction.
  always_comb begin
    out_data_o.force_front_left  = lane_force[0];
    out_data_o.force_front_right = lane_force[1];
    out_data_o.force_rear_left   = lane_force[2];
    out_data_o.force_rear_right  = lane_force[3];
  end

  // The input side only stalls when every pipeline stage holds an item.
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> &valid_q)
    else $error("input stalled with an empty pipeline stage");

  // An accepted transaction always lands in the input stage.
  a_accept_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> valid_q[0])
    else $error("accepted transaction lost at the input stage");

  // Slip never exceeds three, so no force exceeds three times the largest gain.
  a_force_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.force_front_left  <= wsbf_pkg::FORCE_MAX) &&
                    (out_data_o.force_front_right <= wsbf_pkg::FORCE_MAX) &&
                    (out_data_o.force_rear_left   <= wsbf_pkg::FORCE_MAX) &&
                    (out_data_o.force_rear_right  <= wsbf_pkg::FORCE_MAX))
    else $error("brake force out of range");

endmodule

>>> verif/wheel_slip_brake_force_top_tb.sv
// Testbench for wheel_slip_brake_force_top: drives wheel speed items, predicts the brake forces
// and checks every result in order. Depends on wsbf_pkg and the block's RTL.
`timescale 1ns / 1ps

module wheel_slip_brake_force_top_tb;

  localparam int unsigned FRAC       = wsbf_pkg::SLIP_FRAC_BITS_DEF;
  localparam int unsigned HALF_NS    = 10;
  localparam int unsigned TIMEOUT_NS = 10_000_000;
  localparam int unsigned LONG_HOLD  = 150;
  localparam int unsigned TAIL_WAIT  = 40;

  logic                       clk_i       = 1'b0;
  logic                       rst_ni      = 1'b0;
  logic                       in_valid_i  = 1'b0;
  logic                       in_ready_o;
  wsbf_pkg::in_t              in_data_i   = '0;
  logic                       out_valid_o;
  logic                       out_ready_i = 1'b0;
  wsbf_pkg::out_t             out_data_o;
  logic                       cfg_we_i    = 1'b0;
  logic [0:0]                 cfg_idx_i   = wsbf_pkg::CFG_SLIP_THRESHOLD;
  logic [wsbf_pkg::REG_W-1:0] cfg_data_i  = '0;

  // Our copy of the two registers, updated on each write.
  logic [wsbf_pkg::REG_W-1:0] thr_reg  = wsbf_pkg::SLIP_THRESHOLD_RST;
  logic [wsbf_pkg::REG_W-1:0] gain_reg = wsbf_pkg::FORCE_GAIN_RST;

  wsbf_pkg::in_t  wheel_items[$];
  wsbf_pkg::out_t expected_forces[$];

  int unsigned mismatch_cnt = 0;
  bit          in_taken     = 1'b0;
  bit          steady_flow  = 1'b0;
  bit          hold_req     = 1'b0;
  int unsigned send_gap     = 0;
  int unsigned stall_cnt    = 0;
  int unsigned hold_cnt     = 0;

  logic [wsbf_pkg::WHEELS-1:0][wsbf_pkg::FORCE_W-1:0] got_forces;
  logic [wsbf_pkg::WHEELS-1:0][wsbf_pkg::FORCE_W-1:0] want_forces;
  string wheel_name [wsbf_pkg::WHEELS] =
    '{"rear_right", "rear_left", "front_right", "front_left"};

  wheel_slip_brake_force_top i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #(HALF_NS) clk_i = ~clk_i;

  function automatic wsbf_pkg::out_t predict_forces(wsbf_pkg::in_t item);
    logic [wsbf_pkg::WHEELS-1:0][wsbf_pkg::SPEED_W-1:0] spd;
    logic [wsbf_pkg::WHEELS-1:0]                        ok;
    logic [wsbf_pkg::WHEELS-1:0][wsbf_pkg::FORCE_W-1:0] force_val;
    bit [63:0] v;
    bit [63:0] sum;
    bit [63:0] dev;
    bit [63:0] slip;
    spd = {item.speed_front_left, item.speed_front_right,
           item.speed_rear_left, item.speed_rear_right};
    ok  = {item.ok_front_left, item.ok_front_right, item.ok_rear_left, item.ok_rear_right};
    sum = '0;
    for (int k = 0; k < wsbf_pkg::WHEELS; k++) begin
      sum += ok[k] ? 64'(spd[k]) : 64'd0;
    end
    for (int k = 0; k < wsbf_pkg::WHEELS; k++) begin
      force_val[k] = '0;
      if (sum != 0) begin
        // The mean is kept exact by comparing four times the speed with the sum.
        v    = ok[k] ? 64'(spd[k]) * 4 : 64'd0;
        dev  = (v >= sum) ? v - sum : sum - v;
        slip = (dev << FRAC) / sum;
        if (slip > 64'(thr_reg)) begin
          force_val[k] = wsbf_pkg::FORCE_W'((64'(gain_reg) * slip) >> FRAC);
        end
      end
    end
    return wsbf_pkg::out_t'(force_val);
  endfunction

  function automatic wsbf_pkg::in_t make_item(input logic [wsbf_pkg::SPEED_W-1:0] fl,
                                              input logic [wsbf_pkg::SPEED_W-1:0] fr,
                                              input logic [wsbf_pkg::SPEED_W-1:0] rl,
                                              input logic [wsbf_pkg::SPEED_W-1:0] rr,
                                              input logic [3:0] ok);
    wsbf_pkg::in_t it;
    it.speed_front_left  = fl;
    it.speed_front_right = fr;
    it.speed_rear_left   = rl;
    it.speed_rear_right  = rr;
    {it.ok_front_left, it.ok_front_right, it.ok_rear_left, it.ok_rear_right} = ok;
    return it;
  endfunction

  function automatic wsbf_pkg::in_t random_wheels();
    logic [wsbf_pkg::WHEELS-1:0][wsbf_pkg::SPEED_W-1:0] spd;
    logic [3:0]  ok;
    int unsigned style;
    int          base;
    int          spread;
    int          val;
    style  = $urandom_range(0, 9);
    base   = $urandom_range(0, 65535);
    spread = (base >> 2) + 1;
    for (int k = 0; k < wsbf_pkg::WHEELS; k++) begin
      if (style < 4) begin
        // Wheels close to a common speed, so slips land around typical thresholds.
        val = base + int'($urandom_range(0, 2 * spread)) - spread;
        if (val < 0) val = 0;
        if (val > 65535) val = 65535;
        spd[k] = wsbf_pkg::SPEED_W'(val);
      end else if (style < 7) begin
        spd[k] = wsbf_pkg::SPEED_W'($urandom);
      end else if (style < 9) begin
        spd[k] = wsbf_pkg::SPEED_W'($urandom_range(0, 15));
      end else begin
        spd[k] = wsbf_pkg::SPEED_W'(base);
      end
    end
    // One wheel locked or spinning free.
    if (style == 9) spd[$urandom_range(0, 3)] = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
    for (int k = 0; k < 4; k++) begin
      ok[k] = ($urandom_range(0, 99) < 85);
    end
    if ($urandom_range(0, 19) == 0) ok = '0;
    return make_item(spd[3], spd[2], spd[1], spd[0], ok);
  endfunction

  task automatic queue_corner_items();
    wheel_items.push_back(make_item(16'd0, 16'd0, 16'd0, 16'd0, 4'b1111));
    wheel_items.push_back(make_item(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 4'b1111));
    // Every reading flagged bad gives a zero mean.
    wheel_items.push_back(make_item(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 4'b0000));
    wheel_items.push_back(make_item(16'hFFFF, 16'd0, 16'd0, 16'd0, 4'b1111));
    wheel_items.push_back(make_item(16'd0, 16'd0, 16'd0, 16'd1, 4'b1111));
    // Front left slip exactly at the reset threshold, then one step above it.
    wheel_items.push_back(make_item(16'd21299, 16'd14746, 16'd14746, 16'd14745, 4'b1111));
    wheel_items.push_back(make_item(16'd21300, 16'd14746, 16'd14745, 16'd14745, 4'b1111));
    // A bad reading still counts as zero in the mean.
    wheel_items.push_back(make_item(16'd1000, 16'd1000, 16'd1000, 16'd1000, 4'b0111));
    wheel_items.push_back(make_item(16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 4'b1010));
    wheel_items.push_back(make_item(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 4'b0101));
    wheel_items.push_back(make_item(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0, 4'b1111));
    wheel_items.push_back(make_item(16'd7, 16'd9, 16'd11, 16'd40000, 4'b0001));
    wheel_items.push_back(make_item(16'd1, 16'd2, 16'd3, 16'd4, 4'b1111));
  endtask

  task automatic queue_random(input int unsigned n);
    repeat (n) wheel_items.push_back(random_wheels());
  endtask

  task automatic wait_drained();
    do @(negedge clk_i);
    while (wheel_items.size() != 0 || in_valid_i || expected_forces.size() != 0);
  endtask

  task automatic write_reg(input logic [0:0] idx, input logic [wsbf_pkg::REG_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == wsbf_pkg::CFG_SLIP_THRESHOLD) thr_reg = val;
    else gain_reg = val;
  endtask

  task automatic flag_error(input string msg);
    mismatch_cnt++;
    if (mismatch_cnt <= 10) $display("[%0t] mismatch: %s", $time, msg);
  endtask

  // Sender: holds an offered transaction until it is taken, with random gaps between items.
  always @(negedge clk_i) begin
    if (rst_ni && !(in_valid_i && !in_taken)) begin
      if (send_gap > 0) begin
        send_gap--;
        in_valid_i <= 1'b0;
      end else if (!steady_flow && $urandom_range(0, 99) < 8) begin
        send_gap = $urandom_range(1, 19) - 1;
        in_valid_i <= 1'b0;
      end else if (wheel_items.size() != 0) begin
        in_data_i  <= wheel_items.pop_front();
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver: random stall bursts, plus one long hold-off on request.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (hold_req) begin
        hold_req = 1'b0;
        hold_cnt = LONG_HOLD;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_ready_i <= 1'b0;
      end else if (stall_cnt > 0) begin
        stall_cnt--;
        out_ready_i <= 1'b0;
      end else if (!steady_flow && $urandom_range(0, 99) < 8) begin
        stall_cnt = $urandom_range(1, 19) - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Monitor: records accepted inputs with their predicted forces and checks each result.
  always @(posedge clk_i) begin
    in_taken = rst_ni && in_valid_i && in_ready_o;
    if (in_taken) expected_forces.push_back(predict_forces(in_data_i));
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_forces.size() == 0) begin
        flag_error($sformatf("result %h with nothing expected", out_data_o));
      end else begin
        got_forces  = out_data_o;
        want_forces = expected_forces.pop_front();
        for (int k = 0; k < wsbf_pkg::WHEELS; k++) begin
          if (got_forces[k] !== want_forces[k]) begin
            flag_error($sformatf("force_%s: expected %0d, got %0d",
                                 wheel_name[k], want_forces[k], got_forces[k]));
          end
        end
      end
    end
  end

  initial begin
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset register values.
    queue_corner_items();
    queue_random(200);
    wait_drained();

    // Lowest threshold with the largest gain reaches the top of the force range.
    write_reg(wsbf_pkg::CFG_SLIP_THRESHOLD, 16'd0);
    write_reg(wsbf_pkg::CFG_FORCE_GAIN, 16'hFFFF);
    queue_corner_items();
    queue_random(200);
    wait_drained();

    write_reg(wsbf_pkg::CFG_SLIP_THRESHOLD, 16'hFFFF);
    write_reg(wsbf_pkg::CFG_FORCE_GAIN, 16'd0);
    queue_random(200);
    wait_drained();

    // The receiver holds off long enough for the pipeline to fill and back up.
    write_reg(wsbf_pkg::CFG_SLIP_THRESHOLD, wsbf_pkg::REG_W'($urandom_range(0, 20000)));
    write_reg(wsbf_pkg::CFG_FORCE_GAIN, wsbf_pkg::REG_W'($urandom));
    hold_req = 1'b1;
    queue_random(200);
    wait_drained();
    queue_random(100);
    wait_drained();

    write_reg(wsbf_pkg::CFG_SLIP_THRESHOLD, 16'd49151);
    write_reg(wsbf_pkg::CFG_FORCE_GAIN, wsbf_pkg::REG_W'($urandom));
    queue_random(100);
    wait_drained();

    // Back to the reset values, full rate on both sides.
    write_reg(wsbf_pkg::CFG_SLIP_THRESHOLD, wsbf_pkg::SLIP_THRESHOLD_RST);
    write_reg(wsbf_pkg::CFG_FORCE_GAIN, wsbf_pkg::FORCE_GAIN_RST);
    steady_flow = 1'b1;
    queue_random(150);
    wait_drained();

    repeat (TAIL_WAIT) @(negedge clk_i);
    if (expected_forces.size() != 0) begin
      flag_error($sformatf("%0d results never arrived", expected_forces.size()));
    end
    if (mismatch_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("DONE: errors detected");
    $finish;
  end

endmodule
